[design/lpmr_pkg.sv]
// Shared types and constants for the length-prefixed message ring.
// Used by lpmr_seq and length_prefixed_message_ring; depends on nothing.
`default_nettype none

package lpmr_pkg;

   localparam int FUNC_W   = 2;
   localparam int LEN_W    = 7;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 11;
   localparam int MIN_BODY = 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_HDR  = 2'd0,
      FUNC_PUSH_DATA = 2'd1,
      FUNC_POP       = 2'd2,
      FUNC_IGNORE    = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_REJECT = 2'd1,
      STATUS_EMPTY  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR_WR,
      ST_POP_HDR,
      ST_POP_BODY,
      ST_POP_ZERO
   } state_type;

   typedef struct packed {
      status_type        status;
      logic              data_valid;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  msg_length;
      logic              last_flag;
   } rsp_word_type;

endpackage

`default_nettype wire

[design/lpmr_ram.sv]
// Byte memory of the ring: one write port and one read port with registered data.
// No package dependency.
`default_nettype none

module lpmr_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // Read data holds while no read is issued, so a stalled byte stays put.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/lpmr_seq.sv]
// Sequencer of the message ring: ring indexes, free-space accounting and the
// shared wrapping position incrementer. Depends on lpmr_pkg and lpmr_ram.
`default_nettype none

module lpmr_seq
   import lpmr_pkg::*;
#(
   parameter int RING_BYTES    = 1024,
   parameter int MAX_MSG_BYTES = 64,
   parameter int HEADER_BYTES  = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [CFG_W-1:0]  csr_size,
   input  wire logic              req_fire,
   input  wire func_type          req_func,
   input  wire logic [LEN_W-1:0]  req_len,
   input  wire logic [BYTE_W-1:0] req_byte,
   input  wire logic              out_free,
   output logic                   idle,
   output logic                   rsp_load,
   output rsp_word_type           rsp_word
);

   localparam int POS_W  = $clog2(RING_BYTES);
   localparam int SIZE_W = POS_W + 1;
   localparam int SUM_W  = SIZE_W + 1;
   localparam int HCNT_W = $clog2(HEADER_BYTES + 1);
   localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(HEADER_BYTES - 1);
   localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_MSG_BYTES);

   state_type state_ff, state_in;
   logic [SIZE_W-1:0] body_ff, body_in;
   logic [SIZE_W-1:0] free_ff, free_in;
   logic [POS_W-1:0]  rd_pos_ff, rd_pos_in;
   logic [POS_W-1:0]  wr_pos_ff, wr_pos_in;
   logic [POS_W-1:0]  start_ff, start_in;
   logic [LEN_W-1:0]  pend_ff, pend_in;
   logic              open_ff, open_in;
   logic [HCNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] low_ff, low_in;
   logic              hinz_ff, hinz_in;
   logic [LEN_W-1:0]  mlen_ff, mlen_in;
   logic [LEN_W-1:0]  bidx_ff, bidx_in;

   logic              mem_we, mem_re;
   logic [POS_W-1:0]  mem_wa;
   logic [BYTE_W-1:0] mem_wd, mem_rd;

   logic              inc_sel_rd;
   logic [POS_W-1:0]  inc_base, inc_next;
   logic [SIZE_W-1:0] inc_sum;

   logic [31:0]       cfg_wide, cfg_clamp;
   logic [SIZE_W-1:0] cfg_size;
   logic [SUM_W-1:0]  need, pop_sum;
   logic              reject, empty, hdr_last, body_last;
   logic [BYTE_W-1:0] low_now;
   logic              hinz_now;
   logic [LEN_W-1:0]  mlen_now;

   lpmr_ram #(
      .DEPTH  (RING_BYTES),
      .ADDR_W (POS_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (rd_pos_ff),
      .rd_data (mem_rd)
   );

   // The one position incrementer, shared by the write and read sides.
   assign inc_base = inc_sel_rd ? rd_pos_ff : wr_pos_ff;
   assign inc_sum  = {1'b0, inc_base} + SIZE_W'(1);
   assign inc_next = (inc_sum >= body_ff) ? '0 : inc_sum[POS_W-1:0];

   always_comb begin
      cfg_wide = 32'(csr_size);
      if (cfg_wide < 32'(MIN_BODY)) begin
         cfg_clamp = 32'(MIN_BODY);
      end else if (cfg_wide > 32'(RING_BYTES)) begin
         cfg_clamp = 32'(RING_BYTES);
      end else begin
         cfg_clamp = cfg_wide;
      end
   end
   assign cfg_size = cfg_clamp[SIZE_W-1:0];

   assign need   = SUM_W'(req_len) + SUM_W'(HEADER_BYTES + 1);
   assign reject = open_ff || (req_len > MAX_LEN) || ({1'b0, free_ff} < need);
   assign empty  = rd_pos_ff == (open_ff ? start_ff : wr_pos_ff);

   // Header bytes arrive low byte first; any nonzero upper byte saturates the length.
   assign hdr_last = cnt_ff == HCNT_LAST;
   assign low_now  = (cnt_ff == '0) ? mem_rd : low_ff;
   assign hinz_now = hinz_ff || ((cnt_ff != '0) && (mem_rd != '0));
   assign mlen_now = (hinz_now || (low_now > BYTE_W'(MAX_MSG_BYTES))) ?
                     MAX_LEN : low_now[LEN_W-1:0];
   assign pop_sum  = SUM_W'(free_ff) + SUM_W'(mlen_now) + SUM_W'(HEADER_BYTES);
   assign body_last = (bidx_ff + LEN_W'(1)) == mlen_ff;

   assign idle = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!csr_we && req_fire) begin
               if ((req_func == FUNC_PUSH_HDR) && !reject) begin
                  state_in = ST_HDR_WR;
               end else if ((req_func == FUNC_POP) && !empty) begin
                  state_in = ST_POP_HDR;
               end
            end
         end
         ST_HDR_WR: begin
            if (hdr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP_HDR: begin
            if (hdr_last) begin
               state_in = (mlen_now == '0) ? ST_POP_ZERO : ST_POP_BODY;
            end
         end
         ST_POP_BODY: begin
            if (out_free && body_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP_ZERO: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      body_in    = body_ff;
      free_in    = free_ff;
      rd_pos_in  = rd_pos_ff;
      wr_pos_in  = wr_pos_ff;
      start_in   = start_ff;
      pend_in    = pend_ff;
      open_in    = open_ff;
      cnt_in     = cnt_ff;
      len_in     = len_ff;
      low_in     = low_ff;
      hinz_in    = hinz_ff;
      mlen_in    = mlen_ff;
      bidx_in    = bidx_ff;
      mem_we     = 1'b0;
      mem_wa     = wr_pos_ff;
      mem_wd     = '0;
      mem_re     = 1'b0;
      inc_sel_rd = 1'b0;
      rsp_load   = 1'b0;
      rsp_word   = '0;
      if (csr_we) begin
         body_in   = cfg_size;
         free_in   = cfg_size;
         rd_pos_in = '0;
         wr_pos_in = '0;
         start_in  = '0;
         pend_in   = '0;
         open_in   = 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (req_func)
                     FUNC_PUSH_HDR: begin
                        rsp_load           = 1'b1;
                        rsp_word.last_flag = 1'b1;
                        if (reject) begin
                           rsp_word.status = STATUS_REJECT;
                        end else begin
                           rsp_word.status = STATUS_OK;
                           start_in = wr_pos_ff;
                           free_in  = free_ff - SIZE_W'(SUM_W'(req_len) +
                                                        SUM_W'(HEADER_BYTES));
                           pend_in  = req_len;
                           open_in  = req_len != '0;
                           len_in   = req_len;
                           cnt_in   = '0;
                        end
                     end
                     FUNC_PUSH_DATA: begin
                        if (open_ff) begin
                           mem_we    = 1'b1;
                           mem_wd    = req_byte;
                           wr_pos_in = inc_next;
                           pend_in   = pend_ff - LEN_W'(1);
                           open_in   = pend_ff != LEN_W'(1);
                        end
                     end
                     FUNC_POP: begin
                        if (empty) begin
                           rsp_load           = 1'b1;
                           rsp_word.status    = STATUS_EMPTY;
                           rsp_word.last_flag = 1'b1;
                        end else begin
                           mem_re     = 1'b1;
                           inc_sel_rd = 1'b1;
                           rd_pos_in  = inc_next;
                           cnt_in     = '0;
                           hinz_in    = 1'b0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_HDR_WR: begin
               mem_we    = 1'b1;
               mem_wd    = (cnt_ff == '0) ? BYTE_W'(len_ff) : '0;
               wr_pos_in = inc_next;
               cnt_in    = cnt_ff + HCNT_W'(1);
            end
            ST_POP_HDR: begin
               low_in  = low_now;
               hinz_in = hinz_now;
               if (!hdr_last) begin
                  mem_re     = 1'b1;
                  inc_sel_rd = 1'b1;
                  rd_pos_in  = inc_next;
                  cnt_in     = cnt_ff + HCNT_W'(1);
               end else begin
                  mlen_in = mlen_now;
                  free_in = (pop_sum > SUM_W'(body_ff)) ? body_ff : pop_sum[SIZE_W-1:0];
                  bidx_in = '0;
                  if (mlen_now != '0) begin
                     mem_re     = 1'b1;
                     inc_sel_rd = 1'b1;
                     rd_pos_in  = inc_next;
                  end
               end
            end
            ST_POP_BODY: begin
               if (out_free) begin
                  rsp_load            = 1'b1;
                  rsp_word.status     = STATUS_OK;
                  rsp_word.data_valid = 1'b1;
                  rsp_word.data_byte  = mem_rd;
                  rsp_word.msg_length = mlen_ff;
                  rsp_word.last_flag  = body_last;
                  if (!body_last) begin
                     mem_re     = 1'b1;
                     inc_sel_rd = 1'b1;
                     rd_pos_in  = inc_next;
                     bidx_in    = bidx_ff + LEN_W'(1);
                  end
               end
            end
            ST_POP_ZERO: begin
               if (out_free) begin
                  rsp_load           = 1'b1;
                  rsp_word.status    = STATUS_OK;
                  rsp_word.last_flag = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         body_ff   <= SIZE_W'(RING_BYTES);
         free_ff   <= SIZE_W'(RING_BYTES);
         rd_pos_ff <= '0;
         wr_pos_ff <= '0;
         start_ff  <= '0;
         pend_ff   <= '0;
         open_ff   <= 1'b0;
         cnt_ff    <= '0;
         bidx_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         body_ff   <= body_in;
         free_ff   <= free_in;
         rd_pos_ff <= rd_pos_in;
         wr_pos_ff <= wr_pos_in;
         start_ff  <= start_in;
         pend_ff   <= pend_in;
         open_ff   <= open_in;
         cnt_ff    <= cnt_in;
         bidx_ff   <= bidx_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      low_ff  <= low_in;
      hinz_ff <= hinz_in;
      mlen_ff <= mlen_in;
   end

endmodule

`default_nettype wire

[design/length_prefixed_message_ring.sv]
// Push data word: its byte goes to the open message. Push header: answered, then the
// HEADER_BYTES header bytes are written, during which no word is taken. Pop: header
// reads, then one message byte per cycle while the result register is free; an
// empty or rejected answer is a single word. The byte memory is read one byte per
// cycle with registered data; one incrementer is shared. Reset is synchronous: the
// queue empties, the body size returns to RING_BYTES, the byte memory is not cleared.
`default_nettype none

module length_prefixed_message_ring
   import lpmr_pkg::*;
#(
   parameter int RING_BYTES    = 1024,
   parameter int MAX_MSG_BYTES = 64,
   parameter int HEADER_BYTES  = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CFG_W-1:0]  csr_body_size,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [LEN_W-1:0]  req_msg_length,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic                   rsp_data_valid,
   output logic [BYTE_W-1:0]      rsp_data_byte_res,
   output logic [LEN_W-1:0]       rsp_msg_length_res,
   output logic                   rsp_last_flag
);

   logic         idle, out_free, rsp_load, req_fire, csr_we;
   rsp_word_type rsp_word;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   // The result register frees up in the same cycle its word is taken.
   // A pending register write takes precedence over an input word.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = idle && out_free && !csr_valid;
   assign csr_ready = idle;
   assign req_fire  = req_valid && req_ready;
   assign csr_we    = csr_valid && csr_ready;

   lpmr_seq #(
      .RING_BYTES    (RING_BYTES),
      .MAX_MSG_BYTES (MAX_MSG_BYTES),
      .HEADER_BYTES  (HEADER_BYTES)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_size (csr_body_size),
      .req_fire (req_fire),
      .req_func (func_type'(req_func)),
      .req_len  (req_msg_length),
      .req_byte (req_data_byte),
      .out_free (out_free),
      .idle     (idle),
      .rsp_load (rsp_load),
      .rsp_word (rsp_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff <= rsp_word;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_word_ff.status;
   assign rsp_data_valid     = rsp_word_ff.data_valid;
   assign rsp_data_byte_res  = rsp_word_ff.data_byte;
   assign rsp_msg_length_res = rsp_word_ff.msg_length;
   assign rsp_last_flag      = rsp_word_ff.last_flag;

`ifndef SYNTH
   a_ready_needs_slot: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("input taken while the result register is blocked");

   a_run_holds_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_flag) |-> !req_ready)
      else $error("input taken in the middle of a popped message");

   a_status_word_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> (!rsp_data_valid && rsp_last_flag))
      else $error("reject or empty word carries data or is not last");
`endif

endmodule

`default_nettype wire
